// ----- rtl/core/ihp_pkg.sv -----
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants for the indexed max-heap priority queue.
// ----------------------------------------------------------------------------
package ihp_pkg;

    localparam int HANDLE_W  = 10;
    localparam int HANDLES   = 1024;
    localparam int IN_COST_W = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int REM_W     = 11;

    typedef enum logic [KIND_W-1:0] {
        K_LOAD   = 3'd0,
        K_BUILD  = 3'd1,
        K_UPDATE = 3'd2,
        K_POP    = 3'd3,
        K_SETV   = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NOVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_CK0,
        S_CK1,
        S_SU0,
        S_SU1,
        S_SU2,
        S_SD0,
        S_SD1,
        S_SD2,
        S_SD3,
        S_FIN,
        S_POPCHK,
        S_POP0,
        S_POP1,
        S_POP2,
        S_POP3,
        S_BLD0,
        S_BLD1,
        S_BLD2,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RD_SLOT,
        OP_CK_RD,
        OP_SET_FULL,
        OP_SET_UNK,
        OP_SET_NOVALID,
        OP_LOAD_NEW,
        OP_WR_VALID,
        OP_UPD_START,
        OP_SU_RD,
        OP_SU_RDC,
        OP_SU_MOVE,
        OP_SD_RD,
        OP_SD_RDL,
        OP_SD_RDR,
        OP_SD_MOVE,
        OP_FIN,
        OP_POP_RD0,
        OP_POP_RD1,
        OP_POP_RD2,
        OP_POP_SET,
        OP_POP_GOT,
        OP_BLD_INIT,
        OP_BLD_DEC,
        OP_BLD_RDC,
        OP_BLD_SET,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic latch;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  known;
        logic  s_zero;
        logic  full;
        logic  su_move;
        logic  par_zero;
        logic  moved;
        logic  no_child;
        logic  sd_move;
        logic  top_valid;
        logic  cnt_zero;
        logic  i_zero;
        logic  out_free;
    } t_stat;

endpackage

// ----- rtl/core/ihp_ram.sv -----
// ----------------------------------------------------------------------------
// ihp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ihp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ihp_ctrl
// Sequencer for the heap: decodes each item and steps the datapath through
// handle checks, sift-up, sift-down, pop and build loops.
// ----------------------------------------------------------------------------
module ihp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ihp_pkg::t_stat i_st,
    output ihp_pkg::t_cmd  o_cmd
);

    ihp_pkg::t_state r_state;
    ihp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ihp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ihp_pkg::S_IDLE: begin
                if (i_valid) n_state = ihp_pkg::S_DISP;
            end
            ihp_pkg::S_DISP: begin
                unique case (i_st.kind)
                    ihp_pkg::K_LOAD, ihp_pkg::K_UPDATE, ihp_pkg::K_SETV:
                        n_state = ihp_pkg::S_CK0;
                    ihp_pkg::K_BUILD: n_state = ihp_pkg::S_BLD0;
                    ihp_pkg::K_POP:   n_state = ihp_pkg::S_POP0;
                    default:          n_state = ihp_pkg::S_DONE;
                endcase
            end
            ihp_pkg::S_CK0: n_state = ihp_pkg::S_CK1;
            ihp_pkg::S_CK1: begin
                priority if (!i_st.known || i_st.kind == ihp_pkg::K_SETV)
                    n_state = ihp_pkg::S_DONE;
                else if (i_st.s_zero)
                    n_state = ihp_pkg::S_SD0;
                else
                    n_state = ihp_pkg::S_SU0;
            end
            ihp_pkg::S_SU0: n_state = ihp_pkg::S_SU1;
            ihp_pkg::S_SU1: n_state = ihp_pkg::S_SU2;
            ihp_pkg::S_SU2: begin
                priority if (i_st.su_move)
                    n_state = i_st.par_zero ? ihp_pkg::S_FIN : ihp_pkg::S_SU0;
                else if (i_st.moved)
                    n_state = ihp_pkg::S_FIN;
                else
                    n_state = ihp_pkg::S_SD0;
            end
            ihp_pkg::S_SD0: n_state = i_st.no_child ? ihp_pkg::S_FIN : ihp_pkg::S_SD1;
            ihp_pkg::S_SD1: n_state = ihp_pkg::S_SD2;
            ihp_pkg::S_SD2: n_state = ihp_pkg::S_SD3;
            ihp_pkg::S_SD3: n_state = i_st.sd_move ? ihp_pkg::S_SD0 : ihp_pkg::S_FIN;
            ihp_pkg::S_FIN: begin
                priority if (i_st.kind == ihp_pkg::K_POP)
                    n_state = ihp_pkg::S_POPCHK;
                else if (i_st.kind == ihp_pkg::K_BUILD)
                    n_state = ihp_pkg::S_BLD0;
                else
                    n_state = ihp_pkg::S_DONE;
            end
            ihp_pkg::S_POPCHK: n_state = i_st.top_valid ? ihp_pkg::S_DONE : ihp_pkg::S_POP0;
            ihp_pkg::S_POP0:   n_state = i_st.cnt_zero ? ihp_pkg::S_DONE : ihp_pkg::S_POP1;
            ihp_pkg::S_POP1:   n_state = ihp_pkg::S_POP2;
            ihp_pkg::S_POP2:   n_state = ihp_pkg::S_POP3;
            ihp_pkg::S_POP3:   n_state = ihp_pkg::S_SD0;
            ihp_pkg::S_BLD0:   n_state = i_st.i_zero ? ihp_pkg::S_DONE : ihp_pkg::S_BLD1;
            ihp_pkg::S_BLD1:   n_state = ihp_pkg::S_BLD2;
            ihp_pkg::S_BLD2:   n_state = ihp_pkg::S_SD0;
            ihp_pkg::S_DONE: begin
                if (i_st.out_free) n_state = ihp_pkg::S_IDLE;
            end
            default: n_state = ihp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.latch = 1'b0;
        o_cmd.op    = ihp_pkg::OP_NONE;
        unique case (r_state)
            ihp_pkg::S_IDLE: o_cmd.latch = i_valid;
            ihp_pkg::S_DISP: begin
                unique case (i_st.kind)
                    ihp_pkg::K_LOAD, ihp_pkg::K_UPDATE, ihp_pkg::K_SETV:
                        o_cmd.op = ihp_pkg::OP_RD_SLOT;
                    ihp_pkg::K_BUILD: o_cmd.op = ihp_pkg::OP_BLD_INIT;
                    default:          o_cmd.op = ihp_pkg::OP_NONE;
                endcase
            end
            ihp_pkg::S_CK0: o_cmd.op = ihp_pkg::OP_CK_RD;
            ihp_pkg::S_CK1: begin
                priority if (!i_st.known) begin
                    if (i_st.kind != ihp_pkg::K_LOAD)
                        o_cmd.op = ihp_pkg::OP_SET_UNK;
                    else if (i_st.full)
                        o_cmd.op = ihp_pkg::OP_SET_FULL;
                    else
                        o_cmd.op = ihp_pkg::OP_LOAD_NEW;
                end else if (i_st.kind == ihp_pkg::K_SETV) begin
                    o_cmd.op = ihp_pkg::OP_WR_VALID;
                end else begin
                    o_cmd.op = ihp_pkg::OP_UPD_START;
                end
            end
            ihp_pkg::S_SU0: o_cmd.op = ihp_pkg::OP_SU_RD;
            ihp_pkg::S_SU1: o_cmd.op = ihp_pkg::OP_SU_RDC;
            ihp_pkg::S_SU2: o_cmd.op = i_st.su_move ? ihp_pkg::OP_SU_MOVE : ihp_pkg::OP_NONE;
            ihp_pkg::S_SD0: o_cmd.op = ihp_pkg::OP_SD_RD;
            ihp_pkg::S_SD1: o_cmd.op = ihp_pkg::OP_SD_RDL;
            ihp_pkg::S_SD2: o_cmd.op = ihp_pkg::OP_SD_RDR;
            ihp_pkg::S_SD3: o_cmd.op = i_st.sd_move ? ihp_pkg::OP_SD_MOVE : ihp_pkg::OP_NONE;
            ihp_pkg::S_FIN: o_cmd.op = ihp_pkg::OP_FIN;
            ihp_pkg::S_POPCHK:
                o_cmd.op = i_st.top_valid ? ihp_pkg::OP_POP_GOT : ihp_pkg::OP_NONE;
            ihp_pkg::S_POP0:
                o_cmd.op = i_st.cnt_zero ? ihp_pkg::OP_SET_NOVALID : ihp_pkg::OP_POP_RD0;
            ihp_pkg::S_POP1: o_cmd.op = ihp_pkg::OP_POP_RD1;
            ihp_pkg::S_POP2: o_cmd.op = ihp_pkg::OP_POP_RD2;
            ihp_pkg::S_POP3: o_cmd.op = ihp_pkg::OP_POP_SET;
            ihp_pkg::S_BLD0: o_cmd.op = i_st.i_zero ? ihp_pkg::OP_NONE : ihp_pkg::OP_BLD_DEC;
            ihp_pkg::S_BLD1: o_cmd.op = ihp_pkg::OP_BLD_RDC;
            ihp_pkg::S_BLD2: o_cmd.op = ihp_pkg::OP_BLD_SET;
            ihp_pkg::S_DONE: o_cmd.op = i_st.out_free ? ihp_pkg::OP_OUT : ihp_pkg::OP_NONE;
            default: o_cmd.op = ihp_pkg::OP_NONE;
        endcase
    end

    assign o_stall = (r_state != ihp_pkg::S_IDLE);

endmodule

// ----- rtl/core/ihp_dp.sv -----
// ----------------------------------------------------------------------------
// ihp_dp
// Heap datapath: slot, position, cost and valid memories, the hole registers
// of the sift loops, the entry count and the result register.
// ----------------------------------------------------------------------------
module ihp_dp #(
    parameter int CAPACITY  = 1024,
    parameter int COST_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ihp_pkg::t_cmd                   i_cmd,
    output ihp_pkg::t_stat                  o_st,
    input  logic [ihp_pkg::KIND_W-1:0]      i_kind,
    input  logic [ihp_pkg::HANDLE_W-1:0]    i_handle,
    input  logic [ihp_pkg::IN_COST_W-1:0]   i_cost,
    input  logic                            i_valid_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ihp_pkg::STATUS_W-1:0]    o_status,
    output logic [ihp_pkg::HANDLE_W-1:0]    o_popped_handle,
    output logic [ihp_pkg::IN_COST_W-1:0]   o_popped_cost,
    output logic [ihp_pkg::REM_W-1:0]       o_remaining
);

    localparam int HA_W  = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = CNT_W + 1;
    localparam int HW    = ihp_pkg::HANDLE_W;
    localparam int HX_W  = $clog2(ihp_pkg::HANDLES);

    // latched item
    ihp_pkg::t_kind   r_kind;
    logic [HW-1:0]    r_h;
    logic [COST_BITS-1:0] r_c;
    logic             r_v;

    // work registers
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_i;
    logic [HA_W-1:0]  r_s;
    logic [HA_W-1:0]  r_r;
    logic [HW-1:0]    r_eh;
    logic [COST_BITS-1:0] r_ec;
    logic [HW-1:0]    r_hc;
    logic [HW-1:0]    r_hr;
    logic [COST_BITS-1:0] r_cc;
    logic             r_moved;
    logic [HW-1:0]    r_top;
    logic             r_vt;
    logic [COST_BITS-1:0] r_ct;
    ihp_pkg::t_status r_st;
    logic [HW-1:0]    r_ph;
    logic [COST_BITS-1:0] r_pc;

    // result register
    logic             r_ovalid;
    ihp_pkg::t_status r_o_status;
    logic [HW-1:0]    r_o_ph;
    logic [ihp_pkg::IN_COST_W-1:0] r_o_pc;
    logic [ihp_pkg::REM_W-1:0]     r_o_rem;

    // memory ports
    logic [HA_W-1:0]      heap_raddr;
    logic [HW-1:0]        heap_rdata;
    logic [HX_W-1:0]      slot_raddr;
    logic [HA_W-1:0]      slot_rdata;
    logic [HX_W-1:0]      cost_raddr;
    logic [COST_BITS-1:0] cost_rdata;
    logic [HX_W-1:0]      vld_raddr;
    logic                 vld_rdata;
    logic                 map_we;
    logic [HA_W-1:0]      map_slot;
    logic [HW-1:0]        map_h;
    logic                 cost_we;
    logic                 vld_we;

    // derived values
    logic [CW-1:0]        c1;
    logic [CW-1:0]        c2;
    logic [CW-1:0]        cnt_x;
    logic                 has_right;
    logic                 pick_right;
    logic [COST_BITS-1:0] pick_cost;
    logic [HW-1:0]        pick_h;
    logic [HA_W-1:0]      pick_slot;
    logic [HA_W-1:0]      parent;
    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]     i_m1;
    logic [63:0]          pc64;
    logic [31:0]          cnt32;

    assign c1         = CW'({r_r, 1'b1});
    assign c2         = c1 + CW'(1);
    assign cnt_x      = CW'(r_cnt);
    assign has_right  = (c2 < cnt_x);
    assign pick_right = has_right && (cost_rdata > r_cc);
    assign pick_cost  = pick_right ? cost_rdata : r_cc;
    assign pick_h     = pick_right ? r_hr : r_hc;
    assign pick_slot  = pick_right ? c2[HA_W-1:0] : c1[HA_W-1:0];
    assign parent     = (r_r - HA_W'(1)) >> 1;
    assign cnt_m1     = r_cnt - CNT_W'(1);
    assign i_m1       = r_i - CNT_W'(1);
    assign pc64       = 64'(r_pc);
    assign cnt32      = 32'(r_cnt);

    always_comb begin
        heap_raddr = '0;
        slot_raddr = r_h;
        cost_raddr = '0;
        vld_raddr  = '0;
        map_we     = 1'b0;
        map_slot   = r_r;
        map_h      = r_eh;
        cost_we    = 1'b0;
        vld_we     = 1'b0;
        unique case (i_cmd.op)
            ihp_pkg::OP_CK_RD:   heap_raddr = slot_rdata;
            ihp_pkg::OP_LOAD_NEW: begin
                map_we   = 1'b1;
                map_slot = r_cnt[HA_W-1:0];
                map_h    = r_h;
                cost_we  = 1'b1;
                vld_we   = 1'b1;
            end
            ihp_pkg::OP_WR_VALID: vld_we = 1'b1;
            ihp_pkg::OP_UPD_START: begin
                cost_we = 1'b1;
                vld_we  = (r_kind == ihp_pkg::K_LOAD);
            end
            ihp_pkg::OP_SU_RD:  heap_raddr = parent;
            ihp_pkg::OP_SU_RDC: cost_raddr = heap_rdata;
            ihp_pkg::OP_SU_MOVE: begin
                map_we = 1'b1;
                map_h  = r_hc;
            end
            ihp_pkg::OP_SD_RD:  heap_raddr = c1[HA_W-1:0];
            ihp_pkg::OP_SD_RDL: begin
                cost_raddr = heap_rdata;
                heap_raddr = c2[HA_W-1:0];
            end
            ihp_pkg::OP_SD_RDR: cost_raddr = heap_rdata;
            ihp_pkg::OP_SD_MOVE: begin
                map_we = 1'b1;
                map_h  = pick_h;
            end
            // hole is filled only if the element moved; pop always moves last to top
            ihp_pkg::OP_FIN: map_we = r_moved || (r_kind == ihp_pkg::K_POP);
            ihp_pkg::OP_POP_RD0: heap_raddr = '0;
            ihp_pkg::OP_POP_RD1: begin
                heap_raddr = cnt_m1[HA_W-1:0];
                vld_raddr  = heap_rdata;
                cost_raddr = heap_rdata;
            end
            ihp_pkg::OP_POP_RD2: cost_raddr = heap_rdata;
            ihp_pkg::OP_BLD_DEC: heap_raddr = i_m1[HA_W-1:0];
            ihp_pkg::OP_BLD_RDC: cost_raddr = heap_rdata;
            default: ;
        endcase
    end

    ihp_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_slot),
        .i_wdata (map_h),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    ihp_ram #(.WIDTH(HA_W), .DEPTH(ihp_pkg::HANDLES)) u_slot (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_h),
        .i_wdata (map_slot),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ihp_ram #(.WIDTH(COST_BITS), .DEPTH(ihp_pkg::HANDLES)) u_cost (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (r_h),
        .i_wdata (r_c),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rdata)
    );

    ihp_ram #(.WIDTH(1), .DEPTH(ihp_pkg::HANDLES)) u_vld (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (r_h),
        .i_wdata (r_v),
        .i_raddr (vld_raddr),
        .o_rdata (vld_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == ihp_pkg::OP_LOAD_NEW) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.op == ihp_pkg::OP_POP_RD2) begin
                r_cnt <= cnt_m1;
            end
            if (i_cmd.op == ihp_pkg::OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= ihp_pkg::t_kind'(i_kind);
            r_h    <= i_handle;
            r_c    <= COST_BITS'(i_cost);
            r_v    <= i_valid_req;
            r_st   <= ihp_pkg::ST_DONE;
            r_ph   <= '0;
            r_pc   <= '0;
        end
        unique case (i_cmd.op)
            ihp_pkg::OP_CK_RD:       r_s <= slot_rdata;
            ihp_pkg::OP_SET_FULL:    r_st <= ihp_pkg::ST_FULL;
            ihp_pkg::OP_SET_UNK:     r_st <= ihp_pkg::ST_UNKNOWN;
            ihp_pkg::OP_SET_NOVALID: r_st <= ihp_pkg::ST_NOVALID;
            ihp_pkg::OP_UPD_START: begin
                r_eh    <= r_h;
                r_ec    <= r_c;
                r_r     <= r_s;
                r_moved <= 1'b0;
            end
            ihp_pkg::OP_SU_RDC: r_hc <= heap_rdata;
            ihp_pkg::OP_SU_MOVE: begin
                r_r     <= parent;
                r_moved <= 1'b1;
            end
            ihp_pkg::OP_SD_RDL: r_hc <= heap_rdata;
            ihp_pkg::OP_SD_RDR: begin
                r_cc <= cost_rdata;
                r_hr <= heap_rdata;
            end
            ihp_pkg::OP_SD_MOVE: begin
                r_r     <= pick_slot;
                r_moved <= 1'b1;
            end
            ihp_pkg::OP_POP_RD1: r_top <= heap_rdata;
            ihp_pkg::OP_POP_RD2: begin
                r_eh <= heap_rdata;
                r_vt <= vld_rdata;
                r_ct <= cost_rdata;
            end
            ihp_pkg::OP_POP_SET: begin
                r_ec    <= cost_rdata;
                r_r     <= '0;
                r_moved <= 1'b0;
            end
            ihp_pkg::OP_POP_GOT: begin
                r_ph <= r_top;
                r_pc <= r_ct;
            end
            ihp_pkg::OP_BLD_INIT: r_i <= (r_cnt >> 1) + CNT_W'(1);
            ihp_pkg::OP_BLD_DEC:  r_i <= i_m1;
            ihp_pkg::OP_BLD_RDC:  r_eh <= heap_rdata;
            ihp_pkg::OP_BLD_SET: begin
                r_ec    <= cost_rdata;
                r_r     <= r_i[HA_W-1:0];
                r_moved <= 1'b0;
            end
            ihp_pkg::OP_OUT: begin
                r_o_status <= r_st;
                r_o_ph     <= r_ph;
                r_o_pc     <= pc64[ihp_pkg::IN_COST_W-1:0];
                r_o_rem    <= cnt32[ihp_pkg::REM_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        o_st.kind      = r_kind;
        o_st.known     = (CNT_W'(r_s) < r_cnt) && (heap_rdata == r_h);
        o_st.s_zero    = (r_s == '0);
        o_st.full      = (r_cnt >= CNT_W'(CAPACITY));
        o_st.su_move   = (r_ec > cost_rdata);
        o_st.par_zero  = (parent == '0);
        o_st.moved     = r_moved;
        o_st.no_child  = (c1 >= cnt_x);
        o_st.sd_move   = !(r_ec >= pick_cost);
        o_st.top_valid = r_vt;
        o_st.cnt_zero  = (r_cnt == '0);
        o_st.i_zero    = (r_i == '0);
        o_st.out_free  = !r_ovalid || !i_stall;
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_popped_handle = r_o_ph;
    assign o_popped_cost   = r_o_pc;
    assign o_remaining     = r_o_rem;

endmodule

// ----- rtl/core/indexed_max_heap_lazy_pop.sv -----
// ----------------------------------------------------------------------------
// indexed_max_heap_lazy_pop
// Indexed binary max-heap of entry handles with lazy removal on pop.
// ----------------------------------------------------------------------------
// One item is worked at a time; a new item is taken as soon as the previous
// result sits in the output register, and the input stalls until then. Every
// step of the heap goes through memories with one write and one read port and
// registered reads. An unused kind goes straight to the output and a pop of an
// empty heap ends at once; a load of a new handle, a set-valid or a rejected
// item ends after the handle check. An update, or a load of a handle already
// present, writes the cost and then sifts. A sift-up moves the entry up one
// level per pass while it is larger than its parent, and when the first compare
// fails the entry sifts down instead; a sift-down moves it to the larger child
// per pass and stops when it runs out of children or neither child is larger.
// A pop removes the top entry, moves the last entry to the top and sifts it
// down; it repeats that for each invalid entry it removes, until it removes a
// valid one or the heap runs empty. Build runs a sift-down for each of
// count/2 + 1 slots. No memory clearing after reset is needed.
module indexed_max_heap_lazy_pop #(
    parameter int CAPACITY  = 1024,
    parameter int COST_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ihp_pkg::KIND_W-1:0]      i_kind,
    input  logic [ihp_pkg::HANDLE_W-1:0]    i_handle,
    input  logic [ihp_pkg::IN_COST_W-1:0]   i_cost,
    input  logic                            i_valid_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ihp_pkg::STATUS_W-1:0]    o_status,
    output logic [ihp_pkg::HANDLE_W-1:0]    o_popped_handle,
    output logic [ihp_pkg::IN_COST_W-1:0]   o_popped_cost,
    output logic [ihp_pkg::REM_W-1:0]       o_remaining
);

    ihp_pkg::t_cmd  cmd;
    ihp_pkg::t_stat st;

    ihp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    ihp_dp #(
        .CAPACITY  (CAPACITY),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_kind          (i_kind),
        .i_handle        (i_handle),
        .i_cost          (i_cost),
        .i_valid_req     (i_valid_req),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_popped_handle (o_popped_handle),
        .o_popped_cost   (o_popped_cost),
        .o_remaining     (o_remaining)
    );

endmodule
